[sv/mpa_pkg.sv]
// Shared types and constants of the multipatch primitive assembler.
package mpa_pkg;

	localparam logic [3:0] KIND_STRIP = 4'd0;
	localparam logic [3:0] KIND_FAN   = 4'd1;
	localparam logic [3:0] KIND_OUTER = 4'd2;
	localparam logic [3:0] KIND_INNER = 4'd3;
	localparam logic [3:0] KIND_FIRST = 4'd4;
	localparam logic [3:0] KIND_RING  = 4'd5;
	localparam logic [3:0] KIND_TRI   = 4'd6;

	localparam logic [1:0] OP_TRI = 2'd0;
	localparam logic [1:0] OP_ONE = 2'd1;
	localparam logic [1:0] OP_TWO = 2'd2;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [63:0] x;
		logic [63:0] y;
		logic [63:0] z;
	} vertex_t;

	typedef struct packed {
		logic [1:0] op;
		vertex_t    p0;
		vertex_t    p1;
		vertex_t    p2;
		logic       pb;
		logic       rb;
		logic       rf;
	} job_t;

	typedef struct packed {
		logic              full;
		logic              valid;
		logic [QCNT_W-1:0] count;
	} qstat_t;

endpackage

[sv/mpa_front.sv]
// Front end: tracks part state and turns accepted vertices into emit jobs.
module mpa_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic            shape_start,
	input  logic            part_start,
	input  logic            part_end,
	input  logic [3:0]      part_kind,
	input  logic [63:0]     vert_x,
	input  logic [63:0]     vert_y,
	input  logic [63:0]     vert_z,
	output logic            job_valid,
	output mpa_pkg::job_t   job
);

	mpa_pkg::vertex_t first_q, older_q, newer_q;
	mpa_pkg::vertex_t first_d, older_d, newer_d;
	mpa_pkg::vertex_t v;
	logic [3:0] kind_q, kind;
	logic [1:0] pos_q, pos, pos_d;
	logic       open_q, open_c, open_d;
	logic       start;

	assign v = '{x: vert_x, y: vert_y, z: vert_z};

	always_comb begin
		kind      = part_start ? part_kind : kind_q;
		pos       = part_start ? 2'd0 : pos_q;
		open_c    = shape_start ? 1'b0 : open_q;
		start     = (pos == 2'd0);
		first_d   = first_q;
		older_d   = older_q;
		newer_d   = newer_q;
		pos_d     = pos;
		open_d    = open_c;
		job_valid = 1'b0;
		job       = '{op: mpa_pkg::OP_ONE, p0: v, p1: first_q, p2: v,
			pb: 1'b0, rb: 1'b0, rf: 1'b0};
		case (kind)
			mpa_pkg::KIND_STRIP, mpa_pkg::KIND_FAN, mpa_pkg::KIND_TRI: begin
				if (start) begin
					open_d = 1'b0;
				end
				case (pos)
					2'd0: begin
						if (kind == mpa_pkg::KIND_FAN) begin
							first_d = v;
						end else begin
							older_d = v;
						end
						pos_d = 2'd1;
					end
					2'd1: begin
						newer_d = v;
						pos_d   = 2'd2;
					end
					default: begin
						job_valid = 1'b1;
						job.op    = mpa_pkg::OP_TRI;
						job.p0    = (kind == mpa_pkg::KIND_FAN) ? first_q : older_q;
						job.p1    = newer_q;
						job.p2    = v;
						if (kind == mpa_pkg::KIND_TRI) begin
							pos_d = 2'd0;
						end else begin
							newer_d = v;
							if (kind == mpa_pkg::KIND_STRIP) begin
								older_d = newer_q;
							end
						end
					end
				endcase
			end
			mpa_pkg::KIND_OUTER, mpa_pkg::KIND_INNER,
			mpa_pkg::KIND_FIRST, mpa_pkg::KIND_RING: begin
				job_valid = 1'b1;
				if (start) begin
					if (kind == mpa_pkg::KIND_OUTER || kind == mpa_pkg::KIND_FIRST) begin
						job.pb = 1'b1;
					end else begin
						job.pb = ~open_c;
					end
					job.rb  = 1'b1;
					job.rf  = part_end;
					open_d  = 1'b1;
					first_d = v;
					pos_d   = 2'd1;
				end else if (part_end && (v != first_q)) begin
					job.op = mpa_pkg::OP_TWO;
				end else begin
					job.rf = part_end;
				end
			end
			default: begin
				if (start) begin
					pos_d = 2'd1;
				end
			end
		endcase
		if (part_end) begin
			pos_d = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= '0;
			older_q <= '0;
			newer_q <= '0;
			kind_q  <= '0;
			pos_q   <= '0;
			open_q  <= 1'b0;
		end else if (accept) begin
			first_q <= first_d;
			older_q <= older_d;
			newer_q <= newer_d;
			kind_q  <= kind;
			pos_q   <= pos_d;
			open_q  <= open_d;
		end
	end

endmodule

[sv/mpa_queue.sv]
// Short job queue between the front end and the emitter.
module mpa_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  mpa_pkg::job_t    wr_job,
	input  logic             rd_en,
	output mpa_pkg::job_t    rd_job,
	output mpa_pkg::qstat_t  stat
);

	mpa_pkg::job_t             mem_q [mpa_pkg::QDEPTH];
	logic [mpa_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [mpa_pkg::QCNT_W-1:0] count_q;

	function automatic logic [mpa_pkg::QPTR_W-1:0] next_ptr(
		input logic [mpa_pkg::QPTR_W-1:0] p);
		if (p == mpa_pkg::QPTR_W'(mpa_pkg::QDEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	assign stat.count = count_q;
	assign stat.full  = (count_q == mpa_pkg::QCNT_W'(mpa_pkg::QDEPTH));
	assign stat.valid = (count_q != '0);
	assign rd_job     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (rd_en) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[sv/mpa_back.sv]
// Emitter: expands each job into ring vertices, one per cycle while the receiver takes them, into the output register.
module mpa_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             job_valid,
	input  mpa_pkg::job_t    job,
	output logic             job_done,
	input  logic             out_take,
	output logic             out_valid,
	output mpa_pkg::vertex_t out_vert,
	output logic             out_pb,
	output logic             out_rb,
	output logic             out_rf,
	output logic             out_last
);

	logic [1:0]       idx_q;
	logic             valid_q;
	logic             load;
	logic             last_c, pb_c, rb_c, rf_c;
	mpa_pkg::vertex_t vert_c;

	always_comb begin
		vert_c = job.p0;
		pb_c   = 1'b0;
		rb_c   = 1'b0;
		rf_c   = 1'b0;
		last_c = 1'b0;
		case (job.op)
			mpa_pkg::OP_TRI: begin
				case (idx_q)
					2'd0: begin
						pb_c = 1'b1;
						rb_c = 1'b1;
					end
					2'd1: vert_c = job.p1;
					2'd2: vert_c = job.p2;
					default: begin
						rf_c   = 1'b1;
						last_c = 1'b1;
					end
				endcase
			end
			mpa_pkg::OP_TWO: begin
				if (idx_q != 2'd0) begin
					vert_c = job.p1;
					rf_c   = 1'b1;
					last_c = 1'b1;
				end
			end
			default: begin
				pb_c   = job.pb;
				rb_c   = job.rb;
				rf_c   = job.rf;
				last_c = 1'b1;
			end
		endcase
	end

	assign load      = job_valid && (!valid_q || out_take);
	assign job_done  = load && last_c;
	assign out_valid = valid_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_vert <= vert_c;
			out_pb   <= pb_c;
			out_rb   <= rb_c;
			out_rf   <= rf_c;
			out_last <= last_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= last_c ? 2'd0 : idx_q + 2'd1;
			end
			if (load) begin
				valid_q <= 1'b1;
			end else if (out_take) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

[sv/multipatch_primitive_assembler.sv]
// Top level of the multipatch primitive assembler.
// Usage:
// Vertices enter through a queue-style port: a request is taken at a clock edge
// where push is high and full is low. Each request carries the shape and part
// tags and the raw coordinate bits of one vertex.
// Ring vertices leave through a queue-style port: while empty is low the oldest
// result is on the output ports, and it is taken at an edge where pop is high.
// A strip, fan or triangle vertex that completes a triangle gives four results,
// a ring vertex gives one or two, and other vertices give none.
// The front end takes one vertex per cycle while full is low and writes its job
// into a two-entry queue; the emitter drains one result per cycle from that queue
// while the receiver takes them, so a vertex that makes a triangle holds the emitter for its four results.
// With an idle emitter, the job of a vertex is written into the queue when its
// request is taken, and its first result is then loaded into the output register.
// When the receiver stalls, the output register holds, the queue fills and full
// rises; no result is lost.
// Reset clears all held vertices, the part state and the queue, and leaves the
// block empty and ready.
module multipatch_primitive_assembler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        shape_start,
	input  logic        part_start,
	input  logic        part_end,
	input  logic [3:0]  part_kind,
	input  logic [63:0] vert_x,
	input  logic [63:0] vert_y,
	input  logic [63:0] vert_z,
	output logic        empty,
	input  logic        pop,
	output logic [63:0] out_x,
	output logic [63:0] out_y,
	output logic [63:0] out_z,
	output logic        polygon_begin,
	output logic        ring_begin,
	output logic        ring_finish,
	output logic        last_of_run
);

	mpa_pkg::job_t    front_job, head_job;
	mpa_pkg::qstat_t  qstat;
	mpa_pkg::vertex_t out_vert;
	logic             accept, front_valid, job_done, out_valid;

	assign full   = qstat.full;
	assign accept = push && !qstat.full;
	assign empty  = !out_valid;
	assign out_x  = out_vert.x;
	assign out_y  = out_vert.y;
	assign out_z  = out_vert.z;

	mpa_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.shape_start(shape_start),
		.part_start (part_start),
		.part_end   (part_end),
		.part_kind  (part_kind),
		.vert_x     (vert_x),
		.vert_y     (vert_y),
		.vert_z     (vert_z),
		.job_valid  (front_valid),
		.job        (front_job)
	);

	mpa_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.wr_en (accept && front_valid),
		.wr_job(front_job),
		.rd_en (job_done),
		.rd_job(head_job),
		.stat  (qstat)
	);

	mpa_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(qstat.valid),
		.job      (head_job),
		.job_done (job_done),
		.out_take (pop && out_valid),
		.out_valid(out_valid),
		.out_vert (out_vert),
		.out_pb   (polygon_begin),
		.out_rb   (ring_begin),
		.out_rf   (ring_finish),
		.out_last (last_of_run)
	);

	a_pb_has_rb: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && polygon_begin) |-> ring_begin)
		else $error("polygon start without ring start");

	a_single_ring_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && ring_begin && ring_finish) |-> last_of_run)
		else $error("one-vertex ring is not the last result of its vertex");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.count <= mpa_pkg::QCNT_W'(mpa_pkg::QDEPTH))
		else $error("job queue overflow");

	a_done_needs_job: assert property (@(posedge clk) disable iff (!arst_n)
		job_done |-> qstat.valid)
		else $error("job retired from an empty queue");

endmodule
